FILE: src/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants for the integer matrix multiply unit.
// ----------------------------------------------------------------------------
package imm_pkg;

    // Default sizes
    localparam int MAX_DIM_DEF    = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int DIM_W     = 5;   // width of a dimension register
    localparam int IDX_W     = 4;   // width of a row or column index
    localparam int VAL_W     = 32;  // width of a value field on the ports
    localparam int CFG_IDX_W = 2;   // width of the register index
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    // Command codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_LOAD_X   = 2'd0,
        OP_LOAD_Y   = 2'd1,
        OP_MULTIPLY = 2'd2,
        OP_READ_Z   = 2'd3
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_M  = 2'd0,
        CFG_COLS_N  = 2'd1,
        CFG_INNER_K = 2'd2
    } cfg_index_t;

    // Control states, one-hot
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

endpackage

FILE: src/imm_ram.sv
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, hold data while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/integer_matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply_unit
// Integer matrix multiply Z = X * Y with X, Y and Z held in on-chip RAMs.
// ----------------------------------------------------------------------------
// Each request carries a command in s_tuser: load one X element, load one Y
// element, multiply, or read one Z element; every request gives exactly one
// response (read value and status). Loads and reads sustain one request per
// cycle while the response side is not backed up, and their response passes
// through the pending register and the output register. A multiply walks
// rows_m * cols_n * inner_k products, one per cycle, limited by the single
// read port of the X and Y RAMs, then drains the pipeline and finishes; no
// request is taken meanwhile. After reset a clearing pass zeroes every cell
// of the Z RAM before the first request is taken; configuration writes are
// accepted at any time. Out-of-range indexes give status 1 and change nothing.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_unit #(
    parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = imm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [imm_pkg::S_TDATA_W-1:0]  s_tdata,   // row[3:0], col[7:4], value[39:8]
    input  logic [imm_pkg::S_TUSER_W-1:0]  s_tuser,   // opcode[1:0]
    // Response stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [imm_pkg::M_TDATA_W-1:0]  m_tdata,   // read_value[31:0], status[32], zero[39:33]
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [imm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]      cfg_data
);

    localparam int DIM_W   = imm_pkg::DIM_W;
    localparam int VAL_W   = imm_pkg::VAL_W;
    localparam int EW      = ELEM_WIDTH;
    localparam int CELLS   = MAX_DIM * MAX_DIM;
    localparam int AW      = $clog2(CELLS);
    localparam int LW      = (EW + 1) / 2;
    localparam int HW      = EW - LW;
    localparam int DIM_MAX = (MAX_DIM < 31) ? MAX_DIM : 31;
    localparam int DIM_RST = (MAX_DIM < 16) ? MAX_DIM : 16;

    localparam logic [DIM_W-1:0] DIM_ONE  = DIM_W'(1);
    localparam logic [AW-1:0]    CLR_LAST = AW'(CELLS - 1);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [AW-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                                input logic [DIM_W-1:0] c);
        int a;
        a = int'(r) * MAX_DIM + int'(c);
        return AW'(a);
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_ONE;
        end else if (int'(v) > DIM_MAX) begin
            r = DIM_W'(DIM_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    imm_pkg::state_t  state_reg, state_next;
    logic [DIM_W-1:0] m_dim_reg, n_dim_reg, k_dim_reg;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [DIM_W-1:0] i_reg, i_next, j_reg, j_next, l_reg, l_next;
    logic             issue_done_reg, issue_done_next;

    logic             s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [AW-1:0]    s1_zaddr_reg;
    logic             s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [AW-1:0]    s2_zaddr_reg;
    logic [EW-1:0]    s2_p_ll_reg;
    logic [HW-1:0]    s2_p_hl_reg, s2_p_lh_reg;
    logic             s3_valid_reg, s3_first_reg, s3_last_reg;
    logic [AW-1:0]    s3_zaddr_reg;
    logic [EW-1:0]    s3_prod_reg;
    logic [EW-1:0]    acc_reg;

    logic             pend_valid_reg, pend_valid_next;
    logic             pend_status_reg, pend_status_next;
    logic             pend_read_reg, pend_read_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_status_reg;
    logic [VAL_W-1:0] m_value_reg;

    logic             s_accept, out_can_take, pend_free, pend_move, new_pend;
    logic             issuing, pipe_empty, last_l, last_j, last_i;
    imm_pkg::opcode_t s_op;
    logic [DIM_W-1:0] s_row, s_col;
    logic [VAL_W-1:0] s_value;
    logic             x_ok, y_ok, z_ok, req_status;
    logic [63:0]      val_wide, z_wide;
    logic [EW-1:0]    load_elem;
    logic [AW-1:0]    load_addr;

    logic             x_we, y_we, z_we, z_re;
    logic [AW-1:0]    x_raddr, y_raddr, z_waddr;
    logic [EW-1:0]    x_rdata, y_rdata, z_rdata, z_wdata;
    logic [LW-1:0]    x_lo, y_lo;
    logic [HW-1:0]    x_hi, y_hi, cross_sum;
    logic [EW-1:0]    acc_sum;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign s_op    = imm_pkg::opcode_t'(s_tuser);
    assign s_row   = {1'b0, s_tdata[3:0]};
    assign s_col   = {1'b0, s_tdata[7:4]};
    assign s_value = s_tdata[39:8];

    assign x_ok = (s_row < m_dim_reg) && (s_col < k_dim_reg);
    assign y_ok = (s_row < k_dim_reg) && (s_col < n_dim_reg);
    assign z_ok = (s_row < m_dim_reg) && (s_col < n_dim_reg);

    always_comb begin
        unique case (s_op)
            imm_pkg::OP_LOAD_X:   req_status = !x_ok;
            imm_pkg::OP_LOAD_Y:   req_status = !y_ok;
            imm_pkg::OP_READ_Z:   req_status = !z_ok;
            default:              req_status = 1'b0;
        endcase
    end

    // Sign-extend the value, keep the element width
    assign val_wide  = 64'(signed'(s_value));
    assign load_elem = val_wide[EW-1:0];
    assign load_addr = cell_addr(s_row, s_col);

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_can_take = !m_valid_reg || m_tready;
    assign pend_free    = !pend_valid_reg || out_can_take;
    assign pend_move    = pend_valid_reg && out_can_take;
    assign s_tready     = (state_reg == imm_pkg::ST_IDLE) && pend_free;
    assign s_accept     = s_tvalid && s_tready;
    assign cfg_ready    = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_dim_reg <= DIM_W'(DIM_RST);
            n_dim_reg <= DIM_W'(DIM_RST);
            k_dim_reg <= DIM_W'(DIM_RST);
        end else if (cfg_valid && cfg_ready) begin
            unique case (imm_pkg::cfg_index_t'(cfg_index))
                imm_pkg::CFG_ROWS_M:  m_dim_reg <= clamp_dim(cfg_data);
                imm_pkg::CFG_COLS_N:  n_dim_reg <= clamp_dim(cfg_data);
                imm_pkg::CFG_INNER_K: k_dim_reg <= clamp_dim(cfg_data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: clear pass, product walk, finish
    // ------------------------------------------------------------------
    assign issuing    = (state_reg == imm_pkg::ST_MUL) && !issue_done_reg;
    assign pipe_empty = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;
    assign last_l     = DIM_W'(l_reg + DIM_ONE) == k_dim_reg;
    assign last_j     = DIM_W'(j_reg + DIM_ONE) == n_dim_reg;
    assign last_i     = DIM_W'(i_reg + DIM_ONE) == m_dim_reg;

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        l_next          = l_reg;
        issue_done_next = issue_done_reg;
        new_pend        = 1'b0;
        pend_status_next = pend_status_reg;
        pend_read_next   = pend_read_reg;

        unique case (state_reg)
            imm_pkg::ST_CLEAR: begin
                clr_cnt_next = AW'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = imm_pkg::ST_IDLE;
                end
            end
            imm_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_op == imm_pkg::OP_MULTIPLY) begin
                        state_next      = imm_pkg::ST_MUL;
                        i_next          = '0;
                        j_next          = '0;
                        l_next          = '0;
                        issue_done_next = 1'b0;
                    end else begin
                        new_pend         = 1'b1;
                        pend_status_next = req_status;
                        pend_read_next   = (s_op == imm_pkg::OP_READ_Z) && !req_status;
                    end
                end
            end
            imm_pkg::ST_MUL: begin
                if (issuing) begin
                    l_next = DIM_W'(l_reg + DIM_ONE);
                    if (last_l) begin
                        l_next = '0;
                        j_next = DIM_W'(j_reg + DIM_ONE);
                        if (last_j) begin
                            j_next = '0;
                            i_next = DIM_W'(i_reg + DIM_ONE);
                            if (last_i) begin
                                issue_done_next = 1'b1;
                            end
                        end
                    end
                end else if (pipe_empty) begin
                    state_next = imm_pkg::ST_FIN;
                end
            end
            imm_pkg::ST_FIN: begin
                if (pend_free) begin
                    state_next       = imm_pkg::ST_IDLE;
                    new_pend         = 1'b1;
                    pend_status_next = 1'b0;
                    pend_read_next   = 1'b0;
                end
            end
            default: begin
                state_next = imm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= imm_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            l_reg          <= '0;
            issue_done_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            l_reg          <= l_next;
            issue_done_reg <= issue_done_next;
        end
    end

    // ------------------------------------------------------------------
    // RAM ports
    // ------------------------------------------------------------------
    assign x_we    = s_accept && (s_op == imm_pkg::OP_LOAD_X) && x_ok;
    assign y_we    = s_accept && (s_op == imm_pkg::OP_LOAD_Y) && y_ok;
    assign x_raddr = cell_addr(i_reg, l_reg);
    assign y_raddr = cell_addr(l_reg, j_reg);
    assign z_re    = s_accept && (s_op == imm_pkg::OP_READ_Z) && z_ok;

    // Z writes come from the clear pass or the accumulator
    always_comb begin
        if (state_reg == imm_pkg::ST_CLEAR) begin
            z_we    = 1'b1;
            z_waddr = clr_cnt_reg;
            z_wdata = '0;
        end else begin
            z_we    = s3_valid_reg && s3_last_reg;
            z_waddr = s3_zaddr_reg;
            z_wdata = acc_sum;
        end
    end

    imm_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_x_ram (
        .aclk  (aclk),
        .we    (x_we),
        .waddr (load_addr),
        .wdata (load_elem),
        .re    (issuing),
        .raddr (x_raddr),
        .rdata (x_rdata)
    );

    imm_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_y_ram (
        .aclk  (aclk),
        .we    (y_we),
        .waddr (load_addr),
        .wdata (load_elem),
        .re    (issuing),
        .raddr (y_raddr),
        .rdata (y_rdata)
    );

    imm_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_z_ram (
        .aclk  (aclk),
        .we    (z_we),
        .waddr (z_waddr),
        .wdata (z_wdata),
        .re    (z_re),
        .raddr (load_addr),
        .rdata (z_rdata)
    );

    // ------------------------------------------------------------------
    // Product pipeline: RAM read, partial products, combine, accumulate
    // ------------------------------------------------------------------
    assign x_lo      = x_rdata[LW-1:0];
    assign x_hi      = x_rdata[EW-1:LW];
    assign y_lo      = y_rdata[LW-1:0];
    assign y_hi      = y_rdata[EW-1:LW];
    assign cross_sum = HW'(s2_p_hl_reg + s2_p_lh_reg);
    assign acc_sum   = EW'((s3_first_reg ? '0 : acc_reg) + s3_prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issuing;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        // Stage 1: operands on their way out of the RAMs
        s1_first_reg <= (l_reg == '0);
        s1_last_reg  <= last_l;
        s1_zaddr_reg <= cell_addr(i_reg, j_reg);
        // Stage 2: partial products, low bits only
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_zaddr_reg <= s1_zaddr_reg;
        s2_p_ll_reg  <= EW'((2 * LW)'(x_lo) * (2 * LW)'(y_lo));
        s2_p_hl_reg  <= HW'(x_hi * y_lo);
        s2_p_lh_reg  <= HW'(x_lo * y_hi);
        // Stage 3: full product modulo the element width
        s3_first_reg <= s2_first_reg;
        s3_last_reg  <= s2_last_reg;
        s3_zaddr_reg <= s2_zaddr_reg;
        s3_prod_reg  <= EW'(s2_p_ll_reg + (EW'(cross_sum) << LW));
        // Accumulate the dot product
        if (s3_valid_reg) begin
            acc_reg <= acc_sum;
        end
    end

    // ------------------------------------------------------------------
    // Pending response and output register
    // ------------------------------------------------------------------
    assign pend_valid_next = (pend_valid_reg && !out_can_take) || new_pend;
    assign m_valid_next    = pend_move || (m_valid_reg && !m_tready);
    assign z_wide          = 64'(signed'(z_rdata));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (new_pend) begin
            pend_status_reg <= pend_status_next;
            pend_read_reg   <= pend_read_next;
        end
        if (pend_move) begin
            m_status_reg <= pend_status_reg;
            m_value_reg  <= pend_read_reg ? z_wide[VAL_W-1:0] : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_status_reg, m_value_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_z_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imm_pkg::ST_IDLE) |-> !z_we)
        else $error("Z RAM written while idle");

    a_fin_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imm_pkg::ST_FIN) |-> (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg))
        else $error("multiply finished with products in flight");

    a_pend_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !out_can_take) |=> (pend_valid_reg && $stable(pend_status_reg)
                                                && $stable(pend_read_reg)))
        else $error("pending response lost or overwritten");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg) |-> (m_value_reg == '0))
        else $error("error response carries nonzero data");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the integer matrix multiply unit. A short directed
// table covers reset contents, index limits, register saturation and a small
// multiply; random phases then resize the matrices, load every operand a
// multiply will touch, multiply and read Z back. Each response is checked
// against its typed expectation or an in-bench predictor of X, Y and Z.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  TARGET_REQUESTS = 1250;
    localparam int  IDLE_PCT        = 21;
    localparam int  QUIET_FROM      = 500;      // no idling on either side in this window
    localparam int  QUIET_TO        = 750;
    localparam int  HOLD_AT         = 300;      // response count that starts the long hold-off
    localparam int  HOLD_CYCLES     = 400;
    localparam int  NOISE_PCT       = 12;
    localparam int  MAX_READS       = 24;
    localparam int  FULL_PHASE      = 4;        // phase that uses the full 16 x 16 x 16 size
    localparam int  TAIL_CYCLES     = 16;
    localparam int  CYCLE_LIMIT     = 1000000;
    localparam logic [imm_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        imm_pkg::opcode_t op;
        logic [3:0]      row;
        logic [3:0]      col;
        logic [31:0]     value;
    } request_t;

    typedef struct packed {
        logic [31:0]     read_value;
        logic            status;
    } response_t;

    typedef struct packed {
        logic                           is_config;
        logic [imm_pkg::CFG_IDX_W-1:0]  cfg_idx;
        logic [imm_pkg::DIM_W-1:0]      cfg_val;
        request_t                       req;
        logic                           typed;
        response_t                      typed_resp;
    } directed_row_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [imm_pkg::S_TDATA_W-1:0]   s_tdata   = '0;    // row[3:0], col[7:4], value[39:8]
    logic [imm_pkg::S_TUSER_W-1:0]   s_tuser   = '0;    // opcode[1:0]
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [imm_pkg::M_TDATA_W-1:0]   m_tdata;   // read_value[31:0], status[32], zero[39:33]
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [imm_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [imm_pkg::DIM_W-1:0]       cfg_data  = '0;

    // Predictor state
    logic [31:0]  x_elems [16][16];
    logic [31:0]  y_elems [16][16];
    logic [31:0]  z_elems [16][16];
    bit           x_loaded [16][16];
    bit           y_loaded [16][16];
    int           dim_rows  = 16;
    int           dim_cols  = 16;
    int           dim_inner = 16;

    response_t      pending_responses [$];
    request_t       phase_plan [$];
    directed_row_t  directed_table [$];
    response_t      oldest_response;
    int             requests_sent  = 0;
    int             responses_seen = 0;
    int             error_count    = 0;
    int             hold_left      = 0;
    bit             hold_done      = 1'b0;
    int             cycle_count    = 0;

    integer_matrix_multiply_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Saturate a written dimension into 1..16
    function automatic void apply_register(input logic [imm_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [imm_pkg::DIM_W-1:0] data);
        int v;
        v = int'(data);
        if (v < 1)
            v = 1;
        if (v > imm_pkg::MAX_DIM_DEF)
            v = imm_pkg::MAX_DIM_DEF;
        case (idx)
            imm_pkg::CFG_ROWS_M:  dim_rows  = v;
            imm_pkg::CFG_COLS_N:  dim_cols  = v;
            imm_pkg::CFG_INNER_K: dim_inner = v;
            default: ;
        endcase
    endfunction

    // Update X, Y, Z for one accepted request and return its response
    function automatic response_t compute_response(input request_t req);
        response_t    resp;
        logic [31:0]  acc;
        resp = '0;
        case (req.op)
            imm_pkg::OP_LOAD_X: begin
                if (req.row < dim_rows && req.col < dim_inner) begin
                    x_elems[req.row][req.col]  = req.value;
                    x_loaded[req.row][req.col] = 1'b1;
                end else begin
                    resp.status = 1'b1;
                end
            end
            imm_pkg::OP_LOAD_Y: begin
                if (req.row < dim_inner && req.col < dim_cols) begin
                    y_elems[req.row][req.col]  = req.value;
                    y_loaded[req.row][req.col] = 1'b1;
                end else begin
                    resp.status = 1'b1;
                end
            end
            imm_pkg::OP_MULTIPLY: begin
                for (int i = 0; i < dim_rows; i++) begin
                    for (int j = 0; j < dim_cols; j++) begin
                        acc = '0;
                        for (int l = 0; l < dim_inner; l++)
                            acc = acc + x_elems[i][l] * y_elems[l][j];
                        z_elems[i][j] = acc;
                    end
                end
            end
            default: begin
                if (req.row < dim_rows && req.col < dim_cols)
                    resp.read_value = z_elems[req.row][req.col];
                else
                    resp.status = 1'b1;
            end
        endcase
        return resp;
    endfunction

    function automatic request_t make_request(input imm_pkg::opcode_t op, input int row,
                                              input int col, input logic [31:0] value);
        request_t req;
        req.op    = op;
        req.row   = row[3:0];
        req.col   = col[3:0];
        req.value = value;
        return req;
    endfunction

    // Mix of extremes, small signed values and full-range values
    function automatic logic [31:0] random_value();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3, 4, 5: return 32'($urandom_range(0, 32)) - 32'd16;
            default: return $urandom;
        endcase
    endfunction

    // Any load or read at any index
    function automatic request_t random_request();
        int pick;
        pick = $urandom_range(0, 2);
        case (pick)
            0: return make_request(imm_pkg::OP_LOAD_X, $urandom_range(0, 15),
                                   $urandom_range(0, 15), random_value());
            1: return make_request(imm_pkg::OP_LOAD_Y, $urandom_range(0, 15),
                                   $urandom_range(0, 15), random_value());
            default: return make_request(imm_pkg::OP_READ_Z, $urandom_range(0, 15),
                                         $urandom_range(0, 15), $urandom);
        endcase
    endfunction

    function automatic logic [imm_pkg::DIM_W-1:0] raw_dim(input int d);
        if (d == 1 && $urandom_range(0, 1) == 1)
            return '0;
        if (d == imm_pkg::MAX_DIM_DEF && $urandom_range(0, 1) == 1)
            return imm_pkg::DIM_W'($urandom_range(17, 31));
        return imm_pkg::DIM_W'(d);
    endfunction

    function automatic int pick_dim();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 1;
        if (pick == 1)
            return imm_pkg::MAX_DIM_DEF;
        return $urandom_range(2, 5);
    endfunction

    function automatic directed_row_t row_typed(input imm_pkg::opcode_t op, input int row,
                                                input int col,
                                                input logic [31:0] value,
                                                input logic [31:0] exp_value,
                                                input logic exp_status);
        directed_row_t r;
        r = '0;
        r.req        = make_request(op, row, col, value);
        r.typed      = 1'b1;
        r.typed_resp = '{read_value: exp_value, status: exp_status};
        return r;
    endfunction

    function automatic directed_row_t row_predicted(input imm_pkg::opcode_t op,
                                                    input int row, input int col,
                                                    input logic [31:0] value);
        directed_row_t r;
        r = '0;
        r.req = make_request(op, row, col, value);
        return r;
    endfunction

    function automatic directed_row_t row_config(input logic [imm_pkg::CFG_IDX_W-1:0] idx,
                                                 input logic [imm_pkg::DIM_W-1:0] val);
        directed_row_t r;
        r = '0;
        r.is_config = 1'b1;
        r.cfg_idx   = idx;
        r.cfg_val   = val;
        return r;
    endfunction

    // Offer one request, idling cycle by cycle at random; the expectation is queued on accept
    task automatic send_request(input request_t req, input bit typed,
                                input response_t typed_resp);
        response_t predicted;
        while (!(requests_sent >= QUIET_FROM && requests_sent < QUIET_TO) &&
               $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.op;
        s_tdata  <= {req.value, req.col, req.row};
        do @(posedge aclk); while (!s_tready);
        predicted = compute_response(req);
        pending_responses.push_back(typed ? typed_resp : predicted);
        requests_sent++;
    endtask

    // Hold the request stream until every response is back
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_responses.size() != 0);
    endtask

    task automatic write_register(input logic [imm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [imm_pkg::DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic shuffle_plan();
        request_t tmp;
        int       j;
        for (int i = phase_plan.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp           = phase_plan[i];
            phase_plan[i] = phase_plan[j];
            phase_plan[j] = tmp;
        end
    endtask

    // Shuffle the plan and send it, with stray loads and reads mixed in
    task automatic send_plan();
        shuffle_plan();
        foreach (phase_plan[i]) begin
            if ($urandom_range(0, 99) < NOISE_PCT)
                send_request(random_request(), 1'b0, '0);
            send_request(phase_plan[i], 1'b0, '0);
        end
        phase_plan.delete();
    endtask

    // One resize / load / multiply / read-back pass
    task automatic run_phase(input bit full_size);
        int m, n, k, first, rewrite_pct, multiplies;
        m = full_size ? imm_pkg::MAX_DIM_DEF : pick_dim();
        n = full_size ? imm_pkg::MAX_DIM_DEF : pick_dim();
        k = full_size ? imm_pkg::MAX_DIM_DEF : pick_dim();
        wait_for_drain();
        first = $urandom_range(0, 2);
        for (int r = 0; r < 3; r++) begin
            case ((first + r) % 3)
                0: write_register(imm_pkg::CFG_ROWS_M, raw_dim(m));
                1: write_register(imm_pkg::CFG_COLS_N, raw_dim(n));
                default: write_register(imm_pkg::CFG_INNER_K, raw_dim(k));
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            write_register(CFG_UNMAPPED, imm_pkg::DIM_W'($urandom_range(0, 31)));

        // Load every operand the multiply will read, reloading some at random
        rewrite_pct = (m * k > 40 || k * n > 40) ? 5 : 50;
        for (int i = 0; i < m; i++)
            for (int l = 0; l < k; l++)
                if (!x_loaded[i][l] || $urandom_range(0, 99) < rewrite_pct)
                    phase_plan.push_back(make_request(imm_pkg::OP_LOAD_X, i, l,
                                                      random_value()));
        for (int l = 0; l < k; l++)
            for (int j = 0; j < n; j++)
                if (!y_loaded[l][j] || $urandom_range(0, 99) < rewrite_pct)
                    phase_plan.push_back(make_request(imm_pkg::OP_LOAD_Y, l, j,
                                                      random_value()));
        send_plan();

        // Row, col and value are don't-care for a multiply
        multiplies = ($urandom_range(0, 9) == 0) ? 0 : ($urandom_range(0, 6) == 0 ? 2 : 1);
        repeat (multiplies)
            send_request(make_request(imm_pkg::OP_MULTIPLY, $urandom_range(0, 15),
                                      $urandom_range(0, 15), $urandom), 1'b0, '0);

        // Read back the whole result, or a sample of it when large
        if (m * n <= MAX_READS) begin
            for (int i = 0; i < m; i++)
                for (int j = 0; j < n; j++)
                    phase_plan.push_back(make_request(imm_pkg::OP_READ_Z, i, j, $urandom));
        end else begin
            repeat (MAX_READS)
                phase_plan.push_back(make_request(imm_pkg::OP_READ_Z,
                                                  $urandom_range(0, m - 1),
                                                  $urandom_range(0, n - 1), $urandom));
        end
        send_plan();
    endtask

    // Response check and receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_responses.size() == 0) begin
                    report_mismatch($sformatf("response %0d with no request outstanding",
                                              responses_seen));
                end else begin
                    oldest_response = pending_responses.pop_front();
                    if (m_tdata[31:0] !== oldest_response.read_value)
                        report_mismatch($sformatf("response %0d read_value %h, expected %h",
                                                  responses_seen, m_tdata[31:0],
                                                  oldest_response.read_value));
                    if (m_tdata[32] !== oldest_response.status)
                        report_mismatch($sformatf("response %0d status %b, expected %b",
                                                  responses_seen, m_tdata[32],
                                                  oldest_response.status));
                end
                responses_seen++;
            end
            // One long hold-off so the unit backs up into its request side
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && responses_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= (responses_seen >= QUIET_FROM && responses_seen < QUIET_TO) ||
                            ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int phase_count;

        // Reset state: Z cleared, operands unwritten, config in reset values
        foreach (z_elems[i, j]) begin
            z_elems[i][j]  = '0;
            x_elems[i][j]  = '0;
            y_elems[i][j]  = '0;
            x_loaded[i][j] = 1'b0;
            y_loaded[i][j] = 1'b0;
        end

        directed_table.push_back(row_typed(imm_pkg::OP_READ_Z, 0, 0, 32'h0, 32'h0, 1'b0));
        directed_table.push_back(row_typed(imm_pkg::OP_READ_Z, 15, 15, 32'hffff_ffff,
                                           32'h0, 1'b0));
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_X, 0, 0, 32'h7fff_ffff,
                                           32'h0, 1'b0));
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_X, 15, 15, 32'h8000_0000,
                                           32'h0, 1'b0));
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_Y, 0, 0, 32'hffff_ffff,
                                           32'h0, 1'b0));
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_Y, 15, 15, 32'h0, 32'h0, 1'b0));
        directed_table.push_back(row_config(imm_pkg::CFG_ROWS_M, 5'd2));
        directed_table.push_back(row_config(imm_pkg::CFG_COLS_N, 5'd3));
        directed_table.push_back(row_config(imm_pkg::CFG_INNER_K, 5'd1));
        // Out-of-range indexes on every bound
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_X, 2, 0, 32'h1111_1111,
                                           32'h0, 1'b1));
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_X, 0, 1, 32'h2222_2222,
                                           32'h0, 1'b1));
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_Y, 1, 0, 32'h3333_3333,
                                           32'h0, 1'b1));
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_Y, 0, 3, 32'h4444_4444,
                                           32'h0, 1'b1));
        directed_table.push_back(row_typed(imm_pkg::OP_READ_Z, 2, 0, 32'h0, 32'h0, 1'b1));
        directed_table.push_back(row_typed(imm_pkg::OP_READ_Z, 0, 3, 32'h0, 32'h0, 1'b1));
        // Small 2 x 1 times 1 x 3 multiply, including wraparound of the max product
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_X, 1, 0, 32'd5, 32'h0, 1'b0));
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_Y, 0, 1, 32'hffff_fff9,
                                           32'h0, 1'b0));
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_Y, 0, 2, 32'd3, 32'h0, 1'b0));
        directed_table.push_back(row_typed(imm_pkg::OP_MULTIPLY, 7, 9, 32'hdead_beef,
                                           32'h0, 1'b0));
        directed_table.push_back(row_predicted(imm_pkg::OP_READ_Z, 0, 0, 32'h0));
        directed_table.push_back(row_predicted(imm_pkg::OP_READ_Z, 1, 2, 32'h0));
        directed_table.push_back(row_typed(imm_pkg::OP_READ_Z, 15, 15, 32'h0, 32'h0, 1'b1));
        // Saturating register writes and a write past the register list
        directed_table.push_back(row_config(imm_pkg::CFG_ROWS_M, 5'd0));
        directed_table.push_back(row_config(imm_pkg::CFG_COLS_N, 5'd31));
        directed_table.push_back(row_config(imm_pkg::CFG_INNER_K, 5'd17));
        directed_table.push_back(row_config(CFG_UNMAPPED, 5'd5));
        directed_table.push_back(row_predicted(imm_pkg::OP_READ_Z, 0, 15, 32'h0));
        directed_table.push_back(row_typed(imm_pkg::OP_READ_Z, 1, 0, 32'h0, 32'h0, 1'b1));
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_Y, 15, 15, 32'h1234_5678,
                                           32'h0, 1'b0));
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_X, 0, 15, 32'hdead_beef,
                                           32'h0, 1'b0));
        directed_table.push_back(row_typed(imm_pkg::OP_LOAD_X, 1, 0, 32'h5555_5555,
                                           32'h0, 1'b1));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_table[t]) begin
            if (directed_table[t].is_config) begin
                wait_for_drain();
                write_register(directed_table[t].cfg_idx, directed_table[t].cfg_val);
            end else begin
                send_request(directed_table[t].req, directed_table[t].typed,
                             directed_table[t].typed_resp);
            end
        end

        phase_count = 0;
        while (requests_sent < TARGET_REQUESTS) begin
            run_phase(phase_count == FULL_PHASE);
            phase_count++;
        end

        // Let the last responses come back, then a short tail for strays
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
src/imm_pkg.sv
src/imm_ram.sv
src/integer_matrix_multiply_unit.sv
tb/testbench.sv
